// ===== src/dtdt_pkg.sv =====
`timescale 1ns / 1ps

package dtdt_pkg;

    localparam int unsigned MAG_W    = 64;
    localparam int unsigned DIGITS   = 20;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned BITCNT_W = 6;

    localparam logic [MAG_W-1:0] MOST_NEG = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] MAG_MAX  = {1'b0, {(MAG_W-1){1'b1}}};
    localparam logic [MAG_W-1:0] SEC_MIN  = 64'd316200000;
    localparam logic [MAG_W-1:0] MSEC_MIN = 64'd316200;
    localparam logic [MAG_W-1:0] USEC_MIN = 64'd316;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] MICRO_HI   = 8'hC2;
    localparam logic [7:0] MICRO_LO   = 8'hB5;

    typedef struct packed {
        logic signed [63:0] duration_ns;
        logic [3:0]         significant_digits;
    } in_word_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } out_word_t;

    typedef enum logic [1:0] {
        UNIT_NS,
        UNIT_US,
        UNIT_MS,
        UNIT_S
    } unit_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_INT,
        ST_ZERO,
        ST_POINT,
        ST_FRAC,
        ST_SUFFIX
    } state_t;

    typedef enum logic [2:0] {
        SEL_SIGN,
        SEL_ZERO,
        SEL_DIGIT,
        SEL_POINT,
        SEL_SUFFIX
    } byte_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_DEC,
        IDX_INC,
        IDX_INT,
        IDX_FRAC,
        IDX_SUF
    } idx_op_t;

    typedef struct packed {
        logic      load;
        logic      conv;
        logic      prep;
        logic      emit;
        byte_sel_t sel;
        idx_op_t   idx_op;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic neg;
        logic int_long;
        logic has_frac;
        logic int_last;
        logic frac_last;
        logic suf_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [3:0] unit_point(unit_t u);
        logic [3:0] k;
        case (u)
            UNIT_S:  k = 4'd9;
            UNIT_MS: k = 4'd6;
            UNIT_US: k = 4'd3;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] suffix_last(unit_t u);
        logic [1:0] l;
        case (u)
            UNIT_S:  l = 2'd1;
            UNIT_US: l = 2'd3;
            default: l = 2'd2;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] suffix_byte(unit_t u, logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = CHAR_SPACE;
            2'd1:
            begin
                case (u)
                    UNIT_S:  b = CHAR_S;
                    UNIT_MS: b = CHAR_M;
                    UNIT_US: b = MICRO_HI;
                    default: b = CHAR_N;
                endcase
            end
            2'd2:    b = (u == UNIT_US) ? MICRO_LO : CHAR_S;
            default: b = CHAR_S;
        endcase
        return b;
    endfunction

endpackage

// ===== src/duration_to_decimal_text.sv =====
`timescale 1ns / 1ps
// Each accepted word has its binary magnitude turned into 20 decimal digits one bit
// per cycle, then is written out as n bytes (3 to 19), one byte leaving per cycle
// while the sink is ready; no new word is accepted until its last byte is emitted.
// Reset clears the sequencer, the bit counter and the output valid flag only.

module duration_to_decimal_text (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dtdt_pkg::in_word_t    in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dtdt_pkg::out_word_t   out_word
);

    import dtdt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dtdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dtdt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== src/dtdt_ctrl.sv =====
`timescale 1ns / 1ps

module dtdt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dtdt_pkg::dp_status_t   status,
    output dtdt_pkg::dp_cmd_t      cmd
);

    import dtdt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.conv   = 1'b0;
        cmd.prep   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_DIGIT;
        cmd.idx_op = IDX_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cmd.idx_op = IDX_INT;
                state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                if (!status.neg)
                begin
                    state_next = status.int_long ? ST_INT : ST_ZERO;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SIGN;
                    state_next = status.int_long ? ST_INT : ST_ZERO;
                end
            end
            ST_INT, ST_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = (state_reg == ST_INT) ? SEL_DIGIT : SEL_ZERO;
                    if (state_reg == ST_ZERO || status.int_last)
                    begin
                        if (status.has_frac)
                        begin
                            state_next = ST_POINT;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_SUF;
                            state_next = ST_SUFFIX;
                        end
                    end
                    else
                    begin
                        cmd.idx_op = IDX_DEC;
                    end
                end
            end
            ST_POINT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_POINT;
                    cmd.idx_op = IDX_FRAC;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    if (status.frac_last)
                    begin
                        cmd.idx_op = IDX_SUF;
                        state_next = ST_SUFFIX;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_DEC;
                    end
                end
            end
            ST_SUFFIX:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_SUFFIX;
                    if (status.suf_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dtdt_datapath.sv =====
`timescale 1ns / 1ps

module dtdt_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dtdt_pkg::in_word_t     in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dtdt_pkg::out_word_t    out_word,
    input  dtdt_pkg::dp_cmd_t      cmd,
    output dtdt_pkg::dp_status_t   status
);

    import dtdt_pkg::*;

    logic [MAG_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                neg_reg, neg_next;
    logic [3:0]          sd_reg, sd_next;
    unit_t               unit_reg, unit_next;
    logic [3:0]          keep_reg, keep_next;
    logic                int_long_reg, int_long_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg, out_word_next;

    logic [MAG_W-1:0]    raw;
    logic [MAG_W-1:0]    mag_in;
    unit_t               unit_in;
    logic [BCD_W-1:0]    adj;
    logic [3:0]          dig [DIGITS];
    logic [3:0]          k;
    logic [IDX_W-1:0]    d_comb;
    logic                int_long_comb;
    logic [IDX_W-1:0]    intlen;
    logic signed [6:0]   rem;
    logic [3:0]          keep_max;
    logic [3:0]          keep_comb;
    logic [IDX_W-1:0]    pos;
    logic [3:0]          cur_digit;
    logic [7:0]          byte_sel;

    always_comb
    begin
        raw = in_word.duration_ns;
        if (raw[MAG_W-1])
        begin
            mag_in = (raw == MOST_NEG) ? MAG_MAX : (~raw + 64'd1);
        end
        else
        begin
            mag_in = raw;
        end
        if (mag_in >= SEC_MIN)
        begin
            unit_in = UNIT_S;
        end
        else if (mag_in >= MSEC_MIN)
        begin
            unit_in = UNIT_MS;
        end
        else if (mag_in >= USEC_MIN)
        begin
            unit_in = UNIT_US;
        end
        else
        begin
            unit_in = UNIT_NS;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            dig[i] = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                            (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        k = unit_point(unit_reg);
        d_comb = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (dig[i] != 4'd0)
            begin
                d_comb = IDX_W'(i + 1);
            end
        end
        int_long_comb = d_comb > {1'b0, k};
        intlen = int_long_comb ? (d_comb - {1'b0, k}) : IDX_W'(1);
        rem = $signed({3'b000, sd_reg}) - $signed({2'b00, intlen});
        if (rem <= 7'sd0)
        begin
            keep_max = 4'd0;
        end
        else if (rem < $signed({3'b000, k}))
        begin
            keep_max = rem[3:0];
        end
        else
        begin
            keep_max = k;
        end
        keep_comb = 4'd0;
        for (int j = 1; j <= 9; j++)
        begin
            pos = {1'b0, k} - IDX_W'(j);
            if ((4'(j) <= keep_max) && (4'(j) <= k) && (dig[pos] != 4'd0))
            begin
                keep_comb = 4'(j);
            end
        end
    end

    always_comb
    begin
        cur_digit = dig[idx_reg];
        case (cmd.sel)
            SEL_SIGN:   byte_sel = CHAR_MINUS;
            SEL_ZERO:   byte_sel = CHAR_ZERO;
            SEL_POINT:  byte_sel = CHAR_POINT;
            SEL_DIGIT:  byte_sel = CHAR_ZERO | {4'b0000, cur_digit};
            SEL_SUFFIX: byte_sel = suffix_byte(unit_reg, idx_reg[1:0]);
            default:    byte_sel = CHAR_ZERO;
        endcase
    end

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        neg_next       = neg_reg;
        sd_next        = sd_reg;
        unit_next      = unit_reg;
        keep_next      = keep_reg;
        int_long_next  = int_long_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (cmd.load)
        begin
            bin_next     = mag_in;
            bcd_next     = '0;
            bit_cnt_next = '0;
            neg_next     = raw[MAG_W-1];
            sd_next      = in_word.significant_digits;
            unit_next    = unit_in;
        end
        if (cmd.conv)
        begin
            bcd_next     = {adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            bin_next     = {bin_reg[MAG_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
        end
        if (cmd.prep)
        begin
            keep_next     = keep_comb;
            int_long_next = int_long_comb;
        end

        case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_DEC:  idx_next = idx_reg - IDX_W'(1);
            IDX_INC:  idx_next = idx_reg + IDX_W'(1);
            IDX_INT:  idx_next = d_comb - IDX_W'(1);
            IDX_FRAC: idx_next = {1'b0, k} - IDX_W'(1);
            IDX_SUF:  idx_next = '0;
            default:  idx_next = idx_reg;
        endcase

        if (cmd.emit)
        begin
            out_valid_next          = 1'b1;
            out_word_next.char_byte = byte_sel;
            out_word_next.last_char = (cmd.sel == SEL_SUFFIX) && status.suf_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        status.conv_last = bit_cnt_reg == {BITCNT_W{1'b1}};
        status.neg       = neg_reg;
        status.int_long  = int_long_reg;
        status.has_frac  = keep_reg != 4'd0;
        status.int_last  = idx_reg == {1'b0, k};
        status.frac_last = idx_reg == ({1'b0, k} - {1'b0, keep_reg});
        status.suf_last  = idx_reg[1:0] == suffix_last(unit_reg);
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        sd_reg       <= sd_next;
        unit_reg     <= unit_next;
        keep_reg     <= keep_next;
        int_long_reg <= int_long_next;
        idx_reg      <= idx_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
